// ----- hdl/tcss_pkg.sv -----
// shared widths, register codes, reset values and decision constants of the speed scheduler
package tcss_pkg;

  // field widths
  localparam int ROW_W   = 6;
  localparam int CTR_W   = 7;
  localparam int ERR_W   = 8;
  localparam int RING_W  = 3;
  localparam int CFG_W   = 10;
  localparam int CIDX_W  = 3;
  localparam int SPD_W   = 11;
  localparam int KIND_W  = 2;
  localparam int LOOK_W  = 9;
  localparam int HIST_W  = 8;
  localparam int STOP_W  = 5;

  // default structure
  localparam int DEF_ROWS          = 64;
  localparam int DEF_HISTORY_DEPTH = 5;
  localparam int DEF_SAMPLE_PERIOD = 5;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MIN_SPEED         = 3'd0;
  localparam logic [CIDX_W-1:0] REG_OBSTACLE_SPEED    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SHORTCUT_SPEED    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_SLOPE_SPEED       = 3'd3;
  localparam logic [CIDX_W-1:0] REG_LOOP_ENTRY_SPEED  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_LOOP_INSIDE_SPEED = 3'd5;

  // configuration reset values
  localparam logic [CFG_W-1:0] RST_MIN_SPEED         = 10'd460;
  localparam logic [CFG_W-1:0] RST_OBSTACLE_SPEED    = 10'd250;
  localparam logic [CFG_W-1:0] RST_SHORTCUT_SPEED    = 10'd400;
  localparam logic [CFG_W-1:0] RST_SLOPE_SPEED       = 10'd450;
  localparam logic [CFG_W-1:0] RST_LOOP_ENTRY_SPEED  = 10'd350;
  localparam logic [CFG_W-1:0] RST_LOOP_INSIDE_SPEED = 10'd480;

  // track kinds
  localparam logic [KIND_W-1:0] KIND_CURVE_TO_STRAIGHT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STRAIGHT          = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STRAIGHT_TO_CURVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CURVE             = 2'd3;

  // ring phases
  localparam logic [RING_W-1:0] RING_ENTRY_A  = 3'd1;
  localparam logic [RING_W-1:0] RING_ENTRY_B  = 3'd2;
  localparam logic [RING_W-1:0] RING_INSIDE_A = 3'd3;
  localparam logic [RING_W-1:0] RING_INSIDE_B = 3'd4;

  // look-ahead row selection
  localparam logic [ROW_W-1:0] LOOK_ROW_MIN   = 6'd20;
  localparam logic [ROW_W-1:0] LOOK_ROW_MAX   = 6'd58;
  localparam logic [ROW_W:0]   LOOK_ROW_AHEAD = 7'd5;
  localparam logic [CTR_W:0]   LOOK_CENTRE    = 8'd60;
  localparam logic [LOOK_W-1:0] LOOK_LIMIT    = 9'd400;

  // classification
  localparam logic [HIST_W-1:0] HIST_THRESH = 8'd15;
  localparam logic [ROW_W-1:0]  END_ROW_NEAR = 6'd25;
  localparam logic [LOOK_W-1:0] LOOK_STRAIGHT = 9'd150;

  // speed ladder, step i gives min_speed + i
  localparam int LADDER_N = 7;
  localparam logic [LOOK_W-1:0] LADDER_THR [LADDER_N] =
    '{9'd300, 9'd270, 9'd240, 9'd210, 9'd180, 9'd150, 9'd120};
  localparam logic [SPD_W:0] STEP_FAST  = 12'd5;
  localparam logic [SPD_W:0] STEP_SLOW  = 12'd3;
  localparam logic [SPD_W:0] SPEED_SPAN = 12'd30;

  // shortcut stop delay
  localparam logic [STOP_W-1:0] STOP_DELAY = 5'd30;
  localparam logic [STOP_W-1:0] STOP_MAX   = 5'd31;

endpackage

// ----- hdl/track_class_speed_scheduler.sv -----
// speed scheduler top level: row centre store, error history, classification and speed ladder
// a control tick beat passes through the input register stage (s1), then the result register
// throughput: one input beat per clock while in_stall is low; a row-write beat gives no result beat
// a row-write beat updates the centre store at its accept edge, so a tick right after sees it
// reset (rst_n low, synchronous): config registers to defaults, history, counters and held
//   speed to zero, both pipeline valids cleared; the centre store is not cleared
module track_class_speed_scheduler #(
  parameter int ROWS          = tcss_pkg::DEF_ROWS,
  parameter int HISTORY_DEPTH = tcss_pkg::DEF_HISTORY_DEPTH,
  parameter int SAMPLE_PERIOD = tcss_pkg::DEF_SAMPLE_PERIOD
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [tcss_pkg::ROW_W-1:0]        in_row_index,
  input  logic [tcss_pkg::CTR_W-1:0]        in_row_centre,
  input  logic signed [tcss_pkg::ERR_W-1:0] in_lateral_error,
  input  logic [tcss_pkg::ROW_W-1:0]        in_end_row,
  input  logic                              in_obstacle_flag,
  input  logic                              in_shortcut_flag,
  input  logic [tcss_pkg::RING_W-1:0]       in_ring_state,
  input  logic                              in_ramp_flag,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tcss_pkg::SPD_W-1:0]        out_speed_target,
  output logic [tcss_pkg::KIND_W-1:0]       out_track_kind,
  output logic [tcss_pkg::LOOK_W-1:0]       out_lookahead_tenths,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcss_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [tcss_pkg::CFG_W-1:0]        cfg_data
);

  import tcss_pkg::*;

  localparam int AW  = $clog2(ROWS);
  localparam int SCW = $clog2(SAMPLE_PERIOD + 1);
  localparam logic [AW:0]    ROWS_V = (AW + 1)'(ROWS);
  localparam logic [SCW:0]   SP_V   = (SCW + 1)'(SAMPLE_PERIOD);

  // tick held in the input register stage
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic [ROW_W-1:0]        end_row;
    logic                    obstacle;
    logic                    shortcut;
    logic [RING_W-1:0]       ring;
    logic                    ramp;
  } tick_t;

  // ---------------------------------------------------------------------------
  // configuration registers, always ready; unchecked, user must write only while the block is idle
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] min_speed_r, obstacle_speed_r, shortcut_speed_r;
  logic [CFG_W-1:0] slope_speed_r, loop_entry_speed_r, loop_inside_speed_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r         <= RST_MIN_SPEED;
      obstacle_speed_r    <= RST_OBSTACLE_SPEED;
      shortcut_speed_r    <= RST_SHORTCUT_SPEED;
      slope_speed_r       <= RST_SLOPE_SPEED;
      loop_entry_speed_r  <= RST_LOOP_ENTRY_SPEED;
      loop_inside_speed_r <= RST_LOOP_INSIDE_SPEED;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_SPEED:         min_speed_r         <= cfg_data;
        REG_OBSTACLE_SPEED:    obstacle_speed_r    <= cfg_data;
        REG_SHORTCUT_SPEED:    shortcut_speed_r    <= cfg_data;
        REG_SLOPE_SPEED:       slope_speed_r       <= cfg_data;
        REG_LOOP_ENTRY_SPEED:  loop_entry_speed_r  <= cfg_data;
        REG_LOOP_INSIDE_SPEED: loop_inside_speed_r <= cfg_data;
        default: ; // indexes past the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: input register stage (s1) feeds the result register
  // ---------------------------------------------------------------------------
  logic  s1_valid_r, s1_valid_nxt;
  tick_t s1_r;
  logic  out_valid_r, out_valid_nxt;
  logic  s1_go, in_accept;

  // s1 moves on whenever the result register is empty or its beat is taken
  assign s1_go     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = (in_accept && in_func) || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_go || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r.err      <= in_lateral_error;
      s1_r.end_row  <= in_end_row;
      s1_r.obstacle <= in_obstacle_flag;
      s1_r.shortcut <= in_shortcut_flag;
      s1_r.ring     <= in_ring_state;
      s1_r.ramp     <= in_ramp_flag;
    end
  end

  // ---------------------------------------------------------------------------
  // centre store: one write port for row beats, registered read of the
  // look-ahead row taken at the tick's accept edge
  // ---------------------------------------------------------------------------
  logic [CTR_W-1:0] centre_mem [ROWS];
  logic [CTR_W-1:0] rd_centre_r;
  logic [ROW_W:0]   look_row_ahead;
  logic [ROW_W-1:0] look_row;
  logic             row_in_range;

  // look-ahead row: fixed at row 20 for short tracks, else five rows past the end, capped at row 58
  always_comb begin
    look_row_ahead = {1'b0, in_end_row} + LOOK_ROW_AHEAD;
    if (in_end_row < LOOK_ROW_MIN) begin
      look_row = LOOK_ROW_MIN;
    end else if (look_row_ahead > {1'b0, LOOK_ROW_MAX}) begin
      look_row = LOOK_ROW_MAX;
    end else begin
      look_row = look_row_ahead[ROW_W-1:0];
    end
  end

  assign row_in_range = (AW + 1)'(in_row_index) < ROWS_V;

  always_ff @(posedge clk) begin
    if (in_accept && !in_func && row_in_range) begin
      centre_mem[AW'(in_row_index)] <= in_row_centre;
    end
    if (in_accept) begin
      rd_centre_r <= centre_mem[AW'(look_row)];
    end
  end

  // ---------------------------------------------------------------------------
  // tick state
  // ---------------------------------------------------------------------------
  logic [HIST_W-1:0] hist_r   [HISTORY_DEPTH];
  logic [HIST_W-1:0] hist_nxt [HISTORY_DEPTH];
  logic [SCW-1:0]    sample_count_r, sample_count_nxt;
  logic [SPD_W-1:0]  held_speed_r;
  logic [STOP_W-1:0] stop_count_r, stop_count_nxt;

  logic [SCW:0]      sample_inc;
  logic [HIST_W-1:0] err_abs;

  // absolute error, -128 gives 128 which still fits
  assign err_abs = s1_r.err[ERR_W-1] ? HIST_W'(-s1_r.err) : HIST_W'(s1_r.err);

  // sampling: history shifts toward entry 0 once per sample period
  always_comb begin
    sample_inc = {1'b0, sample_count_r} + 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    if (sample_inc >= SP_V) begin
      sample_count_nxt = '0;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_nxt[i] = hist_r[i+1];
      end
      hist_nxt[HISTORY_DEPTH-1] = err_abs;
    end else begin
      sample_count_nxt = sample_inc[SCW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // look-ahead deviation in tenths: |2*err + 8*(centre - 60)|, clamped
  // ---------------------------------------------------------------------------
  logic signed [CTR_W:0]  centre_off;
  logic signed [SPD_W-1:0] look_sum;
  logic [SPD_W-1:0]        look_mag;
  logic [LOOK_W-1:0]       look_l;

  always_comb begin
    centre_off = $signed({1'b0, rd_centre_r}) - $signed(LOOK_CENTRE);
    look_sum   = $signed({{2{s1_r.err[ERR_W-1]}}, s1_r.err, 1'b0})
               + $signed({centre_off, 3'b000});
    look_mag   = look_sum[SPD_W-1] ? SPD_W'(-look_sum) : SPD_W'(look_sum);
    look_l     = (look_mag > {2'b00, LOOK_LIMIT}) ? LOOK_LIMIT : look_mag[LOOK_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // classification on the three oldest history entries after sampling
  // ---------------------------------------------------------------------------
  logic             hist_high, hist_low;
  logic [KIND_W-1:0] kind;

  always_comb begin
    hist_high = (hist_nxt[0] > HIST_THRESH) && (hist_nxt[1] > HIST_THRESH)
             && (hist_nxt[2] > HIST_THRESH);
    hist_low  = (hist_nxt[0] < HIST_THRESH) && (hist_nxt[1] < HIST_THRESH)
             && (hist_nxt[2] < HIST_THRESH);
    if (hist_high && (s1_r.end_row < END_ROW_NEAR)) begin
      kind = KIND_CURVE_TO_STRAIGHT;
    end else if (hist_low && (look_l <= LOOK_STRAIGHT)) begin
      kind = KIND_STRAIGHT;
    end else if (hist_low) begin
      kind = KIND_STRAIGHT_TO_CURVE;
    end else begin
      kind = KIND_CURVE;
    end
  end

  // ---------------------------------------------------------------------------
  // speed ladder and clamp, then overrides in priority order
  // ---------------------------------------------------------------------------
  logic [SPD_W:0]   min_ext, max_ext, ladder, clamped;
  logic [SPD_W-1:0] speed;

  always_comb begin
    min_ext = {2'b00, min_speed_r};
    max_ext = min_ext + SPEED_SPAN;

    // gentle deviation creeps up; larger deviation picks a ladder step,
    // the highest threshold met winning
    ladder = {1'b0, held_speed_r} + STEP_SLOW;
    for (int i = LADDER_N - 1; i >= 0; i--) begin
      if (look_l >= LADDER_THR[i]) begin
        ladder = min_ext + (SPD_W + 1)'(i);
      end
    end
    if (kind == KIND_CURVE_TO_STRAIGHT) begin
      ladder = {1'b0, held_speed_r} + STEP_FAST;
    end

    clamped = ladder;
    if (clamped > max_ext) clamped = max_ext;
    if (clamped < min_ext) clamped = min_ext;

    // shortcut delay counter clears whenever the flag drops and holds under obstacle
    stop_count_nxt = s1_r.shortcut ? stop_count_r : '0;
    speed = clamped[SPD_W-1:0];
    if (s1_r.obstacle) begin
      speed = {1'b0, obstacle_speed_r};
    end else if (s1_r.shortcut) begin
      if (stop_count_r < STOP_MAX) stop_count_nxt = stop_count_r + 1'b1;
      speed = (stop_count_nxt < STOP_DELAY) ? '0 : {1'b0, shortcut_speed_r};
    end else if ((s1_r.ring == RING_ENTRY_A) || (s1_r.ring == RING_ENTRY_B)) begin
      speed = {1'b0, loop_entry_speed_r};
    end else if ((s1_r.ring == RING_INSIDE_A) || (s1_r.ring == RING_INSIDE_B)) begin
      speed = {1'b0, loop_inside_speed_r};
    end else if (s1_r.ramp) begin
      speed = {1'b0, slope_speed_r};
    end
  end

  // state advances in tick order, together with the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      sample_count_r <= '0;
      held_speed_r   <= '0;
      stop_count_r   <= '0;
    end else if (s1_go) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
      sample_count_r <= sample_count_nxt;
      held_speed_r   <= speed;
      stop_count_r   <= stop_count_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [SPD_W-1:0]  out_speed_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [LOOK_W-1:0] out_look_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_speed_r <= speed;
      out_kind_r  <= kind;
      out_look_r  <= look_l;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_speed_target     = out_speed_r;
  assign out_track_kind       = out_kind_r;
  assign out_lookahead_tenths = out_look_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_go_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("tick left s1 but no result beat is pending");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !s1_go |=> !out_valid_r)
    else $error("result beat taken but still shown");

  a_held_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> held_speed_r == out_speed_r)
    else $error("held speed differs from the shown result");

  a_sample_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (SCW + 1)'(sample_count_r) < SP_V)
    else $error("sample counter ran past its period");

  a_shortcut_stop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_r.shortcut && !s1_r.obstacle && (stop_count_r < STOP_DELAY - 1'b1)
    |=> out_speed_r == '0)
    else $error("shortcut delay did not hold the car stopped");

endmodule
